/* design/urml_pkg.sv */
// Package for the ultrasonic range minimum and lock detector.
// Holds widths, reset values, register indexes and the lane control struct.
// No dependencies; every other design file imports it.
package urml_pkg;

    // Sizing of the scan and of the distance window.
    localparam int SENSOR_COUNT = 4;
    localparam int MIN_WINDOW   = 4;
    localparam int WIN_SLOTS    = (MIN_WINDOW > 1) ? MIN_WINDOW - 1 : 1;

    // Field widths.
    localparam int TICK_W     = 24;
    localparam int SCALE_W    = 24;
    localparam int PROD_W     = TICK_W + SCALE_W;
    localparam int FRAC_W     = 24;
    localparam int DIST_W     = 16;
    localparam int RUN_W      = 8;
    localparam int BATT_RAW_W = 12;
    localparam int BATT_W     = 10;
    localparam int EVT_W      = 7;
    localparam int CNT_W      = $clog2(SENSOR_COUNT + 1);

    // Stream data widths, padded to whole bytes.
    localparam int IN_FIELDS_W  = SENSOR_COUNT * TICK_W + BATT_RAW_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SENSOR_COUNT * DIST_W + 1 + BATT_W + EVT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Saturation limits.
    localparam logic [RUN_W-1:0] RUN_MAX   = 8'd255;
    localparam logic [EVT_W-1:0] EVENT_MAX = 7'd99;

    // Configuration register file.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISTANCE_SCALE = 2'd0,
        REG_STUCK_VALUE    = 2'd1,
        REG_STUCK_LENGTH   = 2'd2
    } cfg_reg_t;

    localparam logic [SCALE_W-1:0] SCALE_RESET        = 24'd6026;
    localparam logic [DIST_W-1:0]  STUCK_VALUE_RESET  = 16'd14;
    localparam logic [RUN_W-1:0]   STUCK_LENGTH_RESET = 8'd80;

    // Pipeline load strobes handed to each lane.
    typedef struct packed {
        logic mul_load;   // capture a new scan into the multiply stage
        logic win_load;   // move the product into the window/run stage
    } lane_ctrl_t;

endpackage

/* design/urml_lane.sv */
// One sensor lane: tick-to-distance multiply, window minimum and lock run counter.
// Depends on urml_pkg for widths and the lane control struct.
module urml_lane
    import urml_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ctrl_t          ctrl,
    input  logic [TICK_W-1:0]   ticks,
    input  logic [SCALE_W-1:0]  distance_scale,
    input  logic [DIST_W-1:0]   stuck_value,
    input  logic [RUN_W-1:0]    stuck_length,
    output logic [DIST_W-1:0]   near_dist,
    output logic                locked
);

    logic [PROD_W-1:0] prod_reg;
    logic [DIST_W-1:0] win_reg [WIN_SLOTS];
    logic [DIST_W-1:0] win_next [WIN_SLOTS];
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;
    logic [DIST_W-1:0] dist_cm;
    logic [DIST_W-1:0] lo_next;
    logic [DIST_W-1:0] near_reg;
    logic              locked_reg;

    // Multiply stage: product of ticks and the Q0.24 scale.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_load)
        begin
            prod_reg <= PROD_W'(ticks) * PROD_W'(distance_scale);
        end
    end

    // Drop the fraction and saturate to the distance width.
    assign dist_cm = (|prod_reg[PROD_W-1:FRAC_W+DIST_W]) ? {DIST_W{1'b1}}
                                                         : prod_reg[FRAC_W+DIST_W-1:FRAC_W];

    // Window minimum, window shift and run count.
    always_comb
    begin
        lo_next = dist_cm;
        for (int k = 0; k < MIN_WINDOW - 1; k++)
        begin
            if (win_reg[k] < lo_next)
            begin
                lo_next = win_reg[k];
            end
        end
        for (int k = WIN_SLOTS - 1; k > 0; k--)
        begin
            win_next[k] = win_reg[k-1];
        end
        win_next[0] = dist_cm;
        if (dist_cm == stuck_value)
        begin
            run_next = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
        end
        else
        begin
            run_next = '0;
        end
    end

    // Window and run state, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_SLOTS; k++)
            begin
                win_reg[k] <= '0;
            end
            run_reg <= '0;
        end
        else if (ctrl.win_load)
        begin
            win_reg <= win_next;
            run_reg <= run_next;
        end
    end

    // Lane results toward the merge stage.
    always_ff @(posedge clk)
    begin
        if (ctrl.win_load)
        begin
            near_reg   <= lo_next;
            locked_reg <= (run_next >= stuck_length);
        end
    end

    assign near_dist = near_reg;
    assign locked    = locked_reg;

endmodule

/* design/urml_merge.sv */
// Merge stage: combines the lane lock flags into the recalibrate flag and event total.
// Depends on urml_pkg; registers the whole result for the output channel.
module urml_merge
    import urml_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [SENSOR_COUNT-1:0][DIST_W-1:0] lane_dist,
    input  logic [SENSOR_COUNT-1:0]             lane_locked,
    input  logic [BATT_W-1:0]                   battery,
    output logic [SENSOR_COUNT-1:0][DIST_W-1:0] near_dist,
    output logic                                recal_needed,
    output logic [BATT_W-1:0]                   battery_level,
    output logic [EVT_W-1:0]                    recal_events_shown
);

    logic [EVT_W-1:0]                    total_reg;
    logic [EVT_W-1:0]                    total_next;
    logic [CNT_W-1:0]                    n_locked;
    logic [EVT_W:0]                      sum;
    logic [SENSOR_COUNT-1:0][DIST_W-1:0] near_reg;
    logic                                recal_reg;
    logic [BATT_W-1:0]                   batt_reg;

    // Each locked sensor adds one; the total holds at its ceiling.
    always_comb
    begin
        n_locked   = CNT_W'($countones(lane_locked));
        sum        = {1'b0, total_reg} + (EVT_W+1)'(n_locked);
        total_next = (sum > {1'b0, EVENT_MAX}) ? EVENT_MAX : sum[EVT_W-1:0];
    end

    // Event total, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (load)
        begin
            total_reg <= total_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            near_reg  <= lane_dist;
            recal_reg <= |lane_locked;
            batt_reg  <= battery;
        end
    end

    assign near_dist          = near_reg;
    assign recal_needed       = recal_reg;
    assign battery_level      = batt_reg;
    assign recal_events_shown = total_reg;

endmodule

/* design/ultrasonic_range_min_and_lock_detect.sv */
// Top level of the ultrasonic range minimum and lock detector.
// Depends on urml_pkg, urml_lane and urml_merge.
//
// Usage:
// Each transaction on the s_axis channel carries one scan: four echo widths
// and a raw battery word. Each scan yields exactly one transaction on m_axis
// with the per-sensor window minimum, the recalibrate flag, the battery level
// and the saturating lock event total.
// The result passes through a multiply stage and a window/run stage in each
// sensor lane, then the merge register, before output valid rises.
// Throughput is one scan per cycle while m_axis is not stalled; the lane
// multipliers and the merge adder are each used once per scan.
// Reset clears the distance windows, run counters and event total, and loads
// the configuration registers with their defaults.
// When the receiver stalls, the result is held on m_axis and the pipeline keeps
// accepting scans until every stage is full; s_axis_tready then drops.
// Configuration writes through cfg_wen take effect on the next cycle and are
// meant to happen while no scan is in flight.
module ultrasonic_range_min_and_lock_detect
    import urml_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Scan input.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: echo_ticks_0, echo_ticks_1, echo_ticks_2, echo_ticks_3, battery_raw, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result output.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: near_dist_0..3, recal_needed, battery_level, recal_events_shown, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [SCALE_W-1:0] scale_reg;
    logic [DIST_W-1:0]  stuck_value_reg;
    logic [RUN_W-1:0]   stuck_length_reg;

    logic               v1_reg;
    logic               v2_reg;
    logic               out_valid_reg;
    logic               en1;
    logic               en2;
    logic               en3;
    logic [BATT_W-1:0]  batt1_reg;
    logic [BATT_W-1:0]  batt2_reg;
    lane_ctrl_t         lane_ctrl;

    logic [SENSOR_COUNT-1:0][DIST_W-1:0] lane_dist;
    logic [SENSOR_COUNT-1:0]             lane_locked;
    logic [SENSOR_COUNT-1:0][DIST_W-1:0] near_dist;
    logic                                recal_needed;
    logic [BATT_W-1:0]                   battery_level;
    logic [EVT_W-1:0]                    recal_events_shown;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg        <= SCALE_RESET;
            stuck_value_reg  <= STUCK_VALUE_RESET;
            stuck_length_reg <= STUCK_LENGTH_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_DISTANCE_SCALE: scale_reg        <= cfg_wdata[SCALE_W-1:0];
                REG_STUCK_VALUE:    stuck_value_reg  <= cfg_wdata[DIST_W-1:0];
                REG_STUCK_LENGTH:   stuck_length_reg <= cfg_wdata[RUN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Each stage advances when the stage after it is empty or moving.
    assign en3           = !out_valid_reg || m_axis_tready;
    assign en2           = !v2_reg || en3;
    assign en1           = !v1_reg || en2;
    assign s_axis_tready = en1;

    assign lane_ctrl.mul_load = s_axis_tvalid && en1;
    assign lane_ctrl.win_load = v1_reg && en2;

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    // Battery level rides along with the scan.
    always_ff @(posedge clk)
    begin
        if (lane_ctrl.mul_load)
        begin
            batt1_reg <= s_axis_tdata[IN_FIELDS_W-1 -: BATT_W];
        end
        if (lane_ctrl.win_load)
        begin
            batt2_reg <= batt1_reg;
        end
    end

    // One lane per sensor.
    for (genvar s = 0; s < SENSOR_COUNT; s++)
    begin : g_lane
        urml_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (lane_ctrl),
            .ticks          (s_axis_tdata[s*TICK_W +: TICK_W]),
            .distance_scale (scale_reg),
            .stuck_value    (stuck_value_reg),
            .stuck_length   (stuck_length_reg),
            .near_dist      (lane_dist[s]),
            .locked         (lane_locked[s])
        );
    end

    urml_merge u_merge (
        .clk                (clk),
        .rst_n              (rst_n),
        .load               (v2_reg && en3),
        .lane_dist          (lane_dist),
        .lane_locked        (lane_locked),
        .battery            (batt2_reg),
        .near_dist          (near_dist),
        .recal_needed       (recal_needed),
        .battery_level      (battery_level),
        .recal_events_shown (recal_events_shown)
    );

    // Output packing, first field in the lowest bits.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({recal_events_shown, battery_level, recal_needed,
                                        near_dist});

endmodule

/* test/tb_ultrasonic_range_min_and_lock_detect.sv */
// Self-checking testbench for the ultrasonic range minimum and lock detector.
// Drives scans on the input stream, predicts each result in a local copy of the
// block's behavior and checks the output stream. Depends on urml_pkg and the DUT.
module tb_ultrasonic_range_min_and_lock_detect
    import urml_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Bit offsets of the result fields inside m_axis_tdata.
    localparam int RECAL_OFS  = SENSOR_COUNT * DIST_W;
    localparam int BATT_OFS   = RECAL_OFS + 1;
    localparam int EVENTS_OFS = BATT_OFS + BATT_W;

    // Cycles to let pass after the last result before touching registers.
    localparam int PIPE_SETTLE = 8;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic [BATT_RAW_W-1:0]                 battery_raw;
        logic [SENSOR_COUNT-1:0][TICK_W-1:0]   ticks;
    } scan_t;

    typedef struct packed {
        logic [EVT_W-1:0]                      recal_events;
        logic [BATT_W-1:0]                     battery_level;
        logic                                  recal_needed;
        logic [SENSOR_COUNT-1:0][DIST_W-1:0]   near_dist;
    } range_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wen       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: echo_ticks_0, echo_ticks_1, echo_ticks_2, echo_ticks_3, battery_raw, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: near_dist_0..3, recal_needed, battery_level, recal_events_shown, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    ultrasonic_range_min_and_lock_detect dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Local copy of the register file.
    logic [SCALE_W-1:0] scale_setting       = SCALE_RESET;
    logic [DIST_W-1:0]  lock_value_setting  = STUCK_VALUE_RESET;
    logic [RUN_W-1:0]   lock_length_setting = STUCK_LENGTH_RESET;

    // Local copy of the block's state.
    logic [DIST_W-1:0] dist_window [SENSOR_COUNT][WIN_SLOTS];
    logic [RUN_W-1:0]  lock_runs [SENSOR_COUNT];
    logic [EVT_W-1:0]  lock_event_total;

    scan_t         scan_q[$];
    range_result_t expected_q[$];
    scan_t         scan_on_bus;
    int            errors = 0;

    // Stimulus shaping state.
    int burst_left = 0;
    int gap_left   = 0;
    int echo_run_left [SENSOR_COUNT];
    bit echo_run_stuck [SENSOR_COUNT];
    int rx_mode      = 0;
    int rx_mode_left = 0;
    logic [7:0] rx_pattern = 8'b1101_0010;

    // Converts each echo width to saturated centimetres, updates the window, the
    // run counters and the event total, and returns the result of the scan.
    function automatic range_result_t predict_scan(scan_t scan);
        range_result_t     res;
        logic [PROD_W-1:0] prod;
        logic [DIST_W-1:0] dist_cm;
        logic [DIST_W-1:0] nearest;
        logic [EVT_W-1:0]  total;
        logic              any_lock;
        any_lock = 1'b0;
        total    = lock_event_total;
        for (int s = 0; s < SENSOR_COUNT; s++)
        begin
            prod = PROD_W'(scan.ticks[s]) * PROD_W'(scale_setting);
            dist_cm = (|prod[PROD_W-1:FRAC_W+DIST_W]) ? '1 : prod[FRAC_W +: DIST_W];
            nearest = dist_cm;
            if (MIN_WINDOW > 1)
            begin
                for (int k = 0; k < WIN_SLOTS; k++)
                    if (dist_window[s][k] < nearest)
                        nearest = dist_window[s][k];
                for (int k = WIN_SLOTS - 1; k > 0; k--)
                    dist_window[s][k] = dist_window[s][k-1];
                dist_window[s][0] = dist_cm;
            end
            if (dist_cm == lock_value_setting)
            begin
                if (lock_runs[s] < RUN_MAX)
                    lock_runs[s] = lock_runs[s] + 1'b1;
            end
            else
                lock_runs[s] = '0;
            if (lock_runs[s] >= lock_length_setting)
            begin
                any_lock = 1'b1;
                if (total < EVENT_MAX)
                    total = total + 1'b1;
            end
            res.near_dist[s] = nearest;
        end
        lock_event_total  = total;
        res.recal_needed  = any_lock;
        res.battery_level = scan.battery_raw[BATT_RAW_W-1:2];
        res.recal_events  = total;
        return res;
    endfunction

    // Smallest echo width that maps to the given distance at the current scale.
    function automatic logic [TICK_W-1:0] ticks_for_cm(logic [DIST_W-1:0] cm);
        logic [63:0] need;
        if (scale_setting == '0)
            return TICK_W'($urandom);
        need = ((64'(cm) << FRAC_W) + 64'(scale_setting) - 64'd1) / 64'(scale_setting);
        return (need > 64'hFF_FFFF) ? '1 : need[TICK_W-1:0];
    endfunction

    // Each sensor alternates between runs at the lock distance, with the odd
    // break, and short stretches of noise and extreme widths.
    function automatic scan_t random_scan();
        scan_t scan;
        for (int s = 0; s < SENSOR_COUNT; s++)
        begin
            if (echo_run_left[s] == 0)
            begin
                echo_run_stuck[s] = ($urandom_range(0, 2) != 0);
                if (!echo_run_stuck[s])
                    echo_run_left[s] = $urandom_range(1, 6);
                else if ($urandom_range(0, 1) == 0)
                    echo_run_left[s] = $urandom_range(lock_length_setting,
                                                      lock_length_setting + 8);
                else
                    echo_run_left[s] = $urandom_range(1, lock_length_setting + 8);
            end
            echo_run_left[s]--;
            if (echo_run_stuck[s] && $urandom_range(0, 49) != 0)
                scan.ticks[s] = ticks_for_cm(lock_value_setting);
            else
                case ($urandom_range(0, 6))
                    0: scan.ticks[s] = '0;
                    1: scan.ticks[s] = '1;
                    2: scan.ticks[s] = ticks_for_cm(lock_value_setting + 1'b1);
                    3: scan.ticks[s] = ticks_for_cm(lock_value_setting - 1'b1);
                    4: scan.ticks[s] = TICK_W'($urandom_range(0, 4095));
                    default: scan.ticks[s] = TICK_W'($urandom);
                endcase
        end
        scan.battery_raw = BATT_RAW_W'($urandom_range(0, 4095));
        return scan;
    endfunction

    task automatic queue_scan(input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1,
                              input logic [TICK_W-1:0] t2, input logic [TICK_W-1:0] t3,
                              input logic [BATT_RAW_W-1:0] batt);
        scan_t scan;
        scan.ticks       = {t3, t2, t1, t0};
        scan.battery_raw = batt;
        scan_q.push_back(scan);
    endtask

    task automatic queue_random_scans(input int count);
        for (int i = 0; i < count; i++)
            scan_q.push_back(random_scan());
    endtask

    // Waits until every scan is sent and every result has come back, then lets
    // the pipeline settle so that a register write cannot meet a scan in flight.
    task automatic wait_drained();
        int guard = 0;
        @(negedge clk);
        while (scan_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
        begin
            @(negedge clk);
            guard++;
            if (guard > DRAIN_LIMIT)
            begin
                $display("%0t: results still missing: %0d expected, none received",
                         $time, expected_q.size());
                errors++;
                break;
            end
        end
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_DISTANCE_SCALE: scale_setting       = data[SCALE_W-1:0];
            REG_STUCK_VALUE:    lock_value_setting  = data[DIST_W-1:0];
            REG_STUCK_LENGTH:   lock_length_setting = data[RUN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Drains the block, loads a new setting (junk in the unused upper bits),
    // then queues a batch of random scans.
    task automatic run_phase(input logic [SCALE_W-1:0] scale, input logic [DIST_W-1:0] value,
                             input logic [RUN_W-1:0] length, input int count);
        wait_drained();
        write_reg(REG_DISTANCE_SCALE, scale);
        write_reg(REG_STUCK_VALUE, {8'($urandom), value});
        write_reg(REG_STUCK_LENGTH, {16'($urandom), length});
        @(negedge clk);
        queue_random_scans(count);
    endtask

    // Scan sender: bursts of random length with random gaps, some long bursts
    // with no gaps at all. The prediction is made when a transaction is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(predict_scan(scan_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (scan_q.size() != 0)
                begin
                    scan_on_bus = scan_q.pop_front();
                    s_axis_tdata  <= IN_DATA_W'(scan_on_bus);
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(50, 200);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: the stall behavior switches between always ready, coin
    // flips, a rotating bit pattern and long stalls.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(32, 200);
        end
        else
            rx_mode_left--;
        rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= rx_pattern[0];
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker: each transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        range_result_t want;
        range_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.near_dist     = m_axis_tdata[RECAL_OFS-1:0];
            got.recal_needed  = m_axis_tdata[RECAL_OFS];
            got.battery_level = m_axis_tdata[BATT_OFS +: BATT_W];
            got.recal_events  = m_axis_tdata[EVENTS_OFS +: EVT_W];
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no scan pending, expected none actual %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                for (int s = 0; s < SENSOR_COUNT; s++)
                    report_field($sformatf("near_dist_%0d", s), 32'(want.near_dist[s]),
                                 32'(got.near_dist[s]));
                report_field("recal_needed", 32'(want.recal_needed),
                             32'(got.recal_needed));
                report_field("battery_level", 32'(want.battery_level),
                             32'(got.battery_level));
                report_field("recal_events_shown", 32'(want.recal_events),
                             32'(got.recal_events));
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        for (int s = 0; s < SENSOR_COUNT; s++)
        begin
            for (int k = 0; k < WIN_SLOTS; k++)
                dist_window[s][k] = '0;
            lock_runs[s]      = '0;
            echo_run_left[s]  = 0;
            echo_run_stuck[s] = 1'b0;
        end
        lock_event_total = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings. The first scans see the cleared window as zeros; then
        // field extremes, alternating bits, a falling and rising window, and a
        // run at the lock distance.
        queue_scan('0, '0, '0, '0, '0);
        queue_scan('1, '1, '1, '1, '1);
        queue_scan(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 12'hAAA);
        queue_scan(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 12'h555);
        queue_scan(24'd400000, 24'd300000, 24'd200000, 24'd100000, 12'd3);
        queue_scan(24'd300000, 24'd400000, 24'd100000, 24'd200000, 12'd4);
        queue_scan(24'd200000, 24'd100000, 24'd400000, 24'd300000, 12'd4092);
        queue_scan(24'd100000, 24'd200000, 24'd300000, 24'd400000, 12'd2048);
        queue_scan('1, '1, '1, '1, 12'd2047);
        queue_scan('1, '1, '1, '1, 12'd1);
        for (int i = 0; i < 6; i++)
            queue_scan(ticks_for_cm(lock_value_setting), ticks_for_cm(lock_value_setting),
                       ticks_for_cm(lock_value_setting + 1'b1),
                       ticks_for_cm(lock_value_setting), 12'd1000);
        queue_random_scans(280);

        // Full scale: long echoes saturate, lock at the top distance after one scan.
        run_phase('1, '1, 8'd1, 250);
        // Zero scale: every distance is zero, lock needs the longest run.
        run_phase('0, '0, 8'd255, 300);
        // Zero run length: every sensor is locked on every scan.
        run_phase(24'd65536, 16'd200, 8'd0, 200);
        run_phase(SCALE_W'($urandom_range(256, 24'hFF_FFFF)),
                  DIST_W'($urandom_range(0, 2000)), RUN_W'($urandom_range(1, 20)), 300);
        // A write to the unused index must leave every register alone.
        wait_drained();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        run_phase(SCALE_RESET, STUCK_VALUE_RESET, STUCK_LENGTH_RESET, 250);

        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

/* ultrasonic_range_min_and_lock_detect.f */
design/urml_pkg.sv
design/urml_lane.sv
design/urml_merge.sv
design/ultrasonic_range_min_and_lock_detect.sv
test/tb_ultrasonic_range_min_and_lock_detect.sv
